// ===== hdl/bzc_pkg.sv =====
// ----------------------------------------------------------------------------
// bzc_pkg
// Shared types and constants of the back-EMF zero-cross commutator.
// ----------------------------------------------------------------------------
package bzc_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_THRESHOLD       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_DUTY_FILTER      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_DUTY_BLANK_TIME  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_DUTY_BLANK_TIME = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STALL_LIMIT          = 3'd4;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Six-step phase codes
   localparam logic [2:0] PHASE_STEP1 = 3'd1;
   localparam logic [2:0] PHASE_STEP2 = 3'd2;
   localparam logic [2:0] PHASE_STEP3 = 3'd3;
   localparam logic [2:0] PHASE_STEP4 = 3'd4;
   localparam logic [2:0] PHASE_STEP5 = 3'd5;
   localparam logic [2:0] PHASE_STEP6 = 3'd6;

   localparam logic [15:0] STALL_LIMIT_RESET = 16'd3200;
   localparam logic [7:0]  HIGH_DUTY_FILTER  = 8'd1;
   localparam logic [7:0]  BLANK_COUNT_MAX   = 8'd255;

   typedef struct packed {
      logic [15:0] duty_threshold;
      logic [7:0]  low_duty_filter_count;
      logic [15:0] low_duty_blank_time;
      logic [15:0] high_duty_blank_time;
      logic [15:0] stall_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  phase_step;
      logic        commutated;
      logic        stall_fault;
      logic [15:0] blank_time;
   } result_type;

endpackage

// ===== hdl/bzc_core.sv =====
// ----------------------------------------------------------------------------
// bzc_core
// Commutation state (phase, blanking counter, stall watchdog) and the
// per-item detection logic that advances it.
// ----------------------------------------------------------------------------
module bzc_core #(
   parameter int unsigned SAMPLE_WIDTH = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  bzc_pkg::cfg_type        cfg,
   input  logic [SAMPLE_WIDTH-1:0] u_voltage,
   input  logic [SAMPLE_WIDTH-1:0] v_voltage,
   input  logic [SAMPLE_WIDTH-1:0] w_voltage,
   input  logic [SAMPLE_WIDTH-1:0] bus_sample,
   input  logic [15:0]             duty,
   input  logic                    masked,
   input  logic                    commutating,
   output bzc_pkg::result_type     result
);
   import bzc_pkg::*;

   logic [2:0]              phase_ff,  phase_in;
   logic [7:0]              blank_ff,  blank_in;
   logic [15:0]             same_ff,   same_in;

   logic                    low_duty;
   logic [7:0]              filter;
   logic [SAMPLE_WIDTH-1:0] half_bus;
   logic [SAMPLE_WIDTH-1:0] bemf;
   logic                    phase_ok;
   logic                    match;
   logic [7:0]              blank_inc;
   logic                    advance;
   logic [15:0]             same_inc;
   logic                    stall;

   // Pick blanking time and filter count from duty
   assign low_duty = duty < cfg.duty_threshold;
   assign filter   = low_duty ? cfg.low_duty_filter_count : HIGH_DUTY_FILTER;
   assign half_bus = bus_sample >> 1;

   // Select the floating phase for the current step
   always_comb begin
      phase_ok = 1'b1;
      unique case (phase_ff)
         PHASE_STEP3, PHASE_STEP6: bemf = u_voltage;
         PHASE_STEP2, PHASE_STEP5: bemf = v_voltage;
         PHASE_STEP1, PHASE_STEP4: bemf = w_voltage;
         default: begin
            bemf     = w_voltage;
            phase_ok = 1'b0;
         end
      endcase
   end

   // Falling crossing in odd steps, rising in even steps
   assign match = phase_ff[0] ? (bemf < half_bus) : (bemf > half_bus);

   // Blanking counter, saturating, and step advance
   always_comb begin
      blank_inc = (blank_ff == BLANK_COUNT_MAX) ? blank_ff : blank_ff + 8'd1;
      advance   = 1'b0;
      blank_in  = blank_ff;
      phase_in  = phase_ff;
      if (!masked && !commutating && phase_ok && match) begin
         if (blank_inc >= filter) begin
            advance  = 1'b1;
            blank_in = '0;
            phase_in = (phase_ff == PHASE_STEP6) ? PHASE_STEP1 : phase_ff + 3'd1;
         end else begin
            blank_in = blank_inc;
         end
      end
   end

   // Stall watchdog: count ticks without a step change
   always_comb begin
      same_inc = same_ff + 16'd1;
      stall    = 1'b0;
      if (advance) begin
         same_in = '0;
      end else if (same_inc >= cfg.stall_limit) begin
         same_in = '0;
         stall   = 1'b1;
      end else begin
         same_in = same_inc;
      end
   end

   always_comb begin
      result.phase_step  = phase_in;
      result.commutated  = advance;
      result.stall_fault = stall;
      result.blank_time  = low_duty ? cfg.low_duty_blank_time : cfg.high_duty_blank_time;
   end

   // Update state on each item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_STEP1;
         blank_ff <= '0;
         same_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         blank_ff <= blank_in;
         same_ff  <= same_in;
      end
   end

endmodule

// ===== hdl/bemf_zero_cross_commutator.sv =====
// ----------------------------------------------------------------------------
// bemf_zero_cross_commutator
// Sensorless six-step commutator driven by back-EMF zero-cross detection.
// Items pass through the input register, then the result register, which
// holds each result until taken; the phase update is combinational.
// Throughput: one item per cycle while the result side does not stall.
// Reset: synchronous; phase returns to step 1, counters and config clear,
// stall limit returns to 3200. No clearing pass.
// ----------------------------------------------------------------------------
module bemf_zero_cross_commutator #(
   parameter int unsigned SAMPLE_WIDTH = 12
) (
   input  logic clock,
   input  logic reset,
   // fields from bit 0: u_voltage, v_voltage, w_voltage, bus sample, duty
   input  logic [((4*SAMPLE_WIDTH+16+7)/8)*8-1:0] req_tdata,
   // fields from bit 0: masked, commutating
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fields from bit 0: phase_step, blank_time
   output logic [23:0] rsp_tdata,
   // fields from bit 0: commutated, stall_fault
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bzc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bzc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import bzc_pkg::*;

   localparam int unsigned SW = SAMPLE_WIDTH;

   cfg_type                 cfg_ff;
   logic                    in_valid_ff;
   logic [SW-1:0]           u_ff, v_ff, w_ff, bus_ff;
   logic [15:0]             duty_ff;
   logic                    masked_ff, commutating_ff;
   logic                    out_valid_ff;
   result_type              result_ff;
   result_type              result_in;
   logic                    out_ready;
   logic                    fire;

   // Configuration writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_threshold        <= '0;
         cfg_ff.low_duty_filter_count <= '0;
         cfg_ff.low_duty_blank_time   <= '0;
         cfg_ff.high_duty_blank_time  <= '0;
         cfg_ff.stall_limit           <= STALL_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DUTY_THRESHOLD:       cfg_ff.duty_threshold        <= csr_data;
            CSR_LOW_DUTY_FILTER:      cfg_ff.low_duty_filter_count <= csr_data[7:0];
            CSR_LOW_DUTY_BLANK_TIME:  cfg_ff.low_duty_blank_time   <= csr_data;
            CSR_HIGH_DUTY_BLANK_TIME: cfg_ff.high_duty_blank_time  <= csr_data;
            CSR_STALL_LIMIT:          cfg_ff.stall_limit           <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline handshake: result slot frees when empty or taken
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         u_ff           <= req_tdata[SW-1:0];
         v_ff           <= req_tdata[2*SW-1:SW];
         w_ff           <= req_tdata[3*SW-1:2*SW];
         bus_ff         <= req_tdata[4*SW-1:3*SW];
         duty_ff        <= req_tdata[4*SW+15:4*SW];
         masked_ff      <= req_tuser[0];
         commutating_ff <= req_tuser[1];
      end
   end

   bzc_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cfg         (cfg_ff),
      .u_voltage   (u_ff),
      .v_voltage   (v_ff),
      .w_voltage   (w_ff),
      .bus_sample  (bus_ff),
      .duty        (duty_ff),
      .masked      (masked_ff),
      .commutating (commutating_ff),
      .result      (result_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff.blank_time, result_ff.phase_step};
   assign rsp_tuser  = {result_ff.stall_fault, result_ff.commutated};

endmodule

// ===== bench/tb_bemf_zero_cross_commutator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bemf_zero_cross_commutator
// Self-checking bench for the back-EMF zero-cross commutator. Sample ticks are
// streamed in under random idling and back-pressure. A local model tracks the
// six-step phase, the blanking counter and the stall watchdog, and every result
// item is checked field by field against the model's expectation.
// ----------------------------------------------------------------------------
module tb_bemf_zero_cross_commutator;
   import bzc_pkg::*;

   localparam int unsigned SAMPLE_WIDTH = 12;
   localparam int unsigned REQ_WIDTH = ((4*SAMPLE_WIDTH+16+7)/8)*8;
   localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_WIDTH) - 1;
   // unused register slot, written once to show it has no effect
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] u_voltage;
      logic [SAMPLE_WIDTH-1:0] v_voltage;
      logic [SAMPLE_WIDTH-1:0] w_voltage;
      logic [SAMPLE_WIDTH-1:0] bus_sample;
      logic [15:0]             duty;
      logic                    masked;
      logic                    commutating;
   } bemf_tick_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic [REQ_WIDTH-1:0]         req_tdata;
   logic [1:0]                   req_tuser;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [23:0]                  rsp_tdata;
   logic [1:0]                   rsp_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [CSR_DATA_WIDTH-1:0]    csr_data;

   // model state and shadow configuration
   cfg_type     shadow_cfg;
   logic [2:0]  cur_phase;
   logic [7:0]  blank_cnt;
   logic [2:0]  last_phase;
   logic [15:0] same_ticks;

   result_type  pending_results[$];
   int          send_idle_pct;
   int          rsp_idle_pct;
   int          hold_left;
   int          error_count;
   int          ticks_sent;
   int          commutations_seen;
   int          stalls_seen;

   bemf_zero_cross_commutator #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Pick the floating phase voltage for a given step
   function automatic logic [SAMPLE_WIDTH-1:0] floating_voltage(bemf_tick_type t,
                                                               logic [2:0] step);
      if (step == PHASE_STEP3 || step == PHASE_STEP6) return t.u_voltage;
      else if (step == PHASE_STEP2 || step == PHASE_STEP5) return t.v_voltage;
      else return t.w_voltage;
   endfunction

   // Advance the commutator model by one tick and return its result
   function automatic result_type advance_commutator(bemf_tick_type t);
      result_type              r;
      logic [7:0]              filter;
      logic [SAMPLE_WIDTH-1:0] half;
      logic [SAMPLE_WIDTH-1:0] bemf;
      logic                    hit;
      r = '0;
      half = t.bus_sample >> 1;
      if (t.duty < shadow_cfg.duty_threshold) begin
         r.blank_time = shadow_cfg.low_duty_blank_time;
         filter = shadow_cfg.low_duty_filter_count;
      end else begin
         r.blank_time = shadow_cfg.high_duty_blank_time;
         filter = HIGH_DUTY_FILTER;
      end
      // zero-cross detection, skipped while blanked or commutating
      if (!t.masked && !t.commutating) begin
         bemf = floating_voltage(t, cur_phase);
         hit = cur_phase[0] ? (bemf < half) : (bemf > half);
         if (hit) begin
            if (blank_cnt != BLANK_COUNT_MAX) blank_cnt = blank_cnt + 8'd1;
            if (blank_cnt >= filter) begin
               blank_cnt = '0;
               cur_phase = (cur_phase == PHASE_STEP6) ? PHASE_STEP1 : 3'(cur_phase + 3'd1);
               r.commutated = 1'b1;
            end
         end
      end
      // stall watchdog on unchanged phase
      if (last_phase == cur_phase) begin
         same_ticks = same_ticks + 16'd1;
         if (same_ticks >= shadow_cfg.stall_limit) begin
            same_ticks = '0;
            r.stall_fault = 1'b1;
         end
      end else begin
         same_ticks = '0;
      end
      last_phase = cur_phase;
      r.phase_step = cur_phase;
      return r;
   endfunction

   function automatic bemf_tick_type make_tick(int u, int v, int w, int bus, int duty,
                                               bit masked, bit commutating);
      bemf_tick_type t;
      t.u_voltage = SAMPLE_WIDTH'(u);
      t.v_voltage = SAMPLE_WIDTH'(v);
      t.w_voltage = SAMPLE_WIDTH'(w);
      t.bus_sample = SAMPLE_WIDTH'(bus);
      t.duty = 16'(duty);
      t.masked = masked;
      t.commutating = commutating;
      return t;
   endfunction

   // Build a tick whose floating phase lands on the chosen side of half bus
   function automatic bemf_tick_type crossing_tick(bit hit, int duty, bit masked,
                                                   bit commutating);
      bemf_tick_type t;
      int            half;
      int            bemf;
      t = make_tick($urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX),
                    $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX, 2),
                    duty, masked, commutating);
      half = int'(t.bus_sample) >> 1;
      if (hit) begin
         bemf = cur_phase[0] ? $urandom_range(half - 1, 0) : $urandom_range(SAMPLE_MAX, half + 1);
      end else if ($urandom_range(3) == 0) begin
         bemf = half;
      end else begin
         bemf = cur_phase[0] ? $urandom_range(SAMPLE_MAX, half) : $urandom_range(half, 0);
      end
      if (cur_phase == PHASE_STEP3 || cur_phase == PHASE_STEP6)
         t.u_voltage = SAMPLE_WIDTH'(bemf);
      else if (cur_phase == PHASE_STEP2 || cur_phase == PHASE_STEP5)
         t.v_voltage = SAMPLE_WIDTH'(bemf);
      else
         t.w_voltage = SAMPLE_WIDTH'(bemf);
      return t;
   endfunction

   // Drive one item and hold it until accepted; caller stands at a falling edge
   task automatic send_tick(bemf_tick_type t);
      int gap;
      req_tdata = {t.duty, t.bus_sample, t.w_voltage, t.v_voltage, t.u_voltage};
      req_tuser = {t.commutating, t.masked};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      ticks_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every expected result has arrived
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [15:0] value);
      wait_idle();
      csr_index = index;
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DUTY_THRESHOLD:       shadow_cfg.duty_threshold = value;
         CSR_LOW_DUTY_FILTER:      shadow_cfg.low_duty_filter_count = value[7:0];
         CSR_LOW_DUTY_BLANK_TIME:  shadow_cfg.low_duty_blank_time = value;
         CSR_HIGH_DUTY_BLANK_TIME: shadow_cfg.high_duty_blank_time = value;
         CSR_STALL_LIMIT:          shadow_cfg.stall_limit = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all_csrs(logic [15:0] threshold, logic [7:0] filter,
                                 logic [15:0] low_mask, logic [15:0] high_mask,
                                 logic [15:0] stall);
      write_csr(CSR_DUTY_THRESHOLD, threshold);
      write_csr(CSR_LOW_DUTY_FILTER, {8'd0, filter});
      write_csr(CSR_LOW_DUTY_BLANK_TIME, low_mask);
      write_csr(CSR_HIGH_DUTY_BLANK_TIME, high_mask);
      write_csr(CSR_STALL_LIMIT, stall);
   endtask

   // Reset configuration: extremes of the fields, suppression, a full turn
   task automatic test_reset_defaults();
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 16'hFFFF, 1, 1));
      send_tick(crossing_tick(1, 0, 1, 0));
      send_tick(crossing_tick(1, 0, 0, 1));
      // floating phase exactly at half bus never counts as a crossing
      send_tick(make_tick(0, 0, 2047, SAMPLE_MAX, 100, 0, 0));
      repeat (7) send_tick(crossing_tick(1, $urandom_range(16'hFFFF), 0, 0));
      send_tick(crossing_tick(0, 16'h8000, 0, 0));
   endtask

   // Duty threshold selects filter and blanking time; equal duty counts as high
   task automatic test_duty_threshold();
      write_all_csrs(16'd1000, 8'd3, 16'h5A5A, 16'hA5A5, STALL_LIMIT_RESET);
      write_csr(CSR_SPARE_INDEX, 16'hFFFF);
      repeat (3) send_tick(crossing_tick(1, 999, 0, 0));
      send_tick(crossing_tick(1, 1000, 0, 0));
      send_tick(crossing_tick(1, 999, 0, 0));
      send_tick(crossing_tick(1, 16'hFFFF, 0, 0));
      // zero filter count commutates on the first match
      write_csr(CSR_LOW_DUTY_FILTER, 16'd0);
      send_tick(crossing_tick(1, 0, 0, 0));
   endtask

   // Stall watchdog, including a limit of zero
   task automatic test_stall_watchdog();
      write_csr(CSR_STALL_LIMIT, 16'd0);
      repeat (2) send_tick(crossing_tick(0, 0, 0, 0));
      write_csr(CSR_STALL_LIMIT, 16'd2);
      repeat (4) send_tick(crossing_tick(0, 0, $urandom_range(1), 0));
   endtask

   // Hold the result side off while items keep coming so the block fills up
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      @(posedge clock);
      hold_left = 60;
      @(negedge clock);
      repeat (40) send_tick(crossing_tick($urandom_range(1), $urandom_range(16'hFFFF),
                                          0, 0));
      while (hold_left > 0) @(negedge clock);
   endtask

   // Random runs under several register settings and idling modes
   task automatic test_random_run();
      bemf_tick_type t;
      int            duty;
      for (int p = 0; p < 8; p++) begin
         if (p == 0)
            write_all_csrs(16'd0, 8'd0, 16'd0, 16'd0, 16'd1);
         else if (p == 1)
            write_all_csrs(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         else
            write_all_csrs(16'($urandom), 8'($urandom_range(8)), 16'($urandom),
                           16'($urandom), 16'($urandom_range(12, 1)));
         if (p < 3) begin
            send_idle_pct = 15;
            rsp_idle_pct = 70;
         end else if (p < 6) begin
            send_idle_pct = 70;
            rsp_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         @(negedge clock);
         repeat (210) begin
            case ($urandom_range(3))
               0: duty = shadow_cfg.duty_threshold;
               1: duty = int'(shadow_cfg.duty_threshold) - 1;
               default: duty = $urandom_range(16'hFFFF);
            endcase
            if ($urandom_range(99) < 80)
               t = crossing_tick($urandom_range(99) < 90, duty, $urandom_range(15) == 0,
                                 $urandom_range(15) == 0);
            else
               t = make_tick($urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX),
                             $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX),
                             $urandom_range(16'hFFFF), $urandom_range(1),
                             $urandom_range(1));
            send_tick(t);
         end
      end
   endtask

   // Result side ready, with random stalls and an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Predict on every accepted item
   always @(posedge clock) begin
      bemf_tick_type t;
      if (!reset && req_tvalid && req_tready) begin
         t.u_voltage = req_tdata[SAMPLE_WIDTH-1:0];
         t.v_voltage = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
         t.w_voltage = req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
         t.bus_sample = req_tdata[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH];
         t.duty = req_tdata[4*SAMPLE_WIDTH+15:4*SAMPLE_WIDTH];
         t.masked = req_tuser[0];
         t.commutating = req_tuser[1];
         pending_results.push_back(advance_commutator(t));
      end
   end

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.phase_step = rsp_tdata[2:0];
         got.blank_time = rsp_tdata[18:3];
         got.commutated = rsp_tuser[0];
         got.stall_fault = rsp_tuser[1];
         if (pending_results.size() == 0) begin
            $error("unexpected result item: phase_step %0d", got.phase_step);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.phase_step !== want.phase_step) begin
               $error("phase_step expected %0d got %0d", want.phase_step, got.phase_step);
               error_count++;
            end
            if (got.commutated !== want.commutated) begin
               $error("commutated expected %0d got %0d", want.commutated, got.commutated);
               error_count++;
            end
            if (got.stall_fault !== want.stall_fault) begin
               $error("stall_fault expected %0d got %0d", want.stall_fault, got.stall_fault);
               error_count++;
            end
            if (got.blank_time !== want.blank_time) begin
               $error("blank_time expected %0h got %0h", want.blank_time, got.blank_time);
               error_count++;
            end
            if (want.commutated) commutations_seen++;
            if (want.stall_fault) stalls_seen++;
         end
      end
   end

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DUTY_THRESHOLD;
      csr_data = '0;
      shadow_cfg = '0;
      shadow_cfg.stall_limit = STALL_LIMIT_RESET;
      cur_phase = PHASE_STEP1;
      last_phase = PHASE_STEP1;
      blank_cnt = '0;
      same_ticks = '0;
      send_idle_pct = 15;
      rsp_idle_pct = 70;
      hold_left = 0;
      error_count = 0;
      ticks_sent = 0;
      commutations_seen = 0;
      stalls_seen = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_duty_threshold();
      test_stall_watchdog();
      test_backpressure();
      test_random_run();

      // drain, then allow the pipeline latency to pass
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Sent %0d ticks under 8 register settings and 3 idling modes,", ticks_sent);
      $display("seeing %0d commutations and %0d stall faults.", commutations_seen,
               stalls_seen);
      if (error_count == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
